### design/mefat_pkg.sv
// Shared types and constants for the multi-echo first-arrival timer.
// No dependencies; imported by every module of the block.
package mefat_pkg;

  // Number of sensors (2..8); echo lines beyond the input width read low
  localparam int NUM_SENSORS = 8;
  localparam int ECHO_W      = 8;
  localparam int NEAREST_W   = 3;
  localparam int ELAPSED_W   = 21;
  localparam int TIMEOUT_W   = 20;
  localparam int TRIG_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 20;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(123694);
  localparam logic [TRIG_W-1:0]    TRIG_RST    = TRIG_W'(10);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'b0001,
    PH_TRIGGER   = 4'b0010,
    PH_WAIT_HIGH = 4'b0100,
    PH_WAIT_DROP = 4'b1000
  } phase_t;

  // One lane's view of its echo line
  typedef struct packed {
    logic high;
    logic first_low;
  } lane_t;

  // One result word
  typedef struct packed {
    logic                 trigger_out;
    logic                 result_valid;
    logic [NEAREST_W-1:0] nearest_sensor;
    logic [ELAPSED_W-1:0] elapsed_ticks;
    logic                 timed_out;
  } result_t;

endpackage

### design/mefat_lane.sv
// One sensor lane: echo level and first-low detection along the prefix chain.
// Depends on mefat_pkg.
module mefat_lane (
  input  logic            echo_bit,
  input  logic            lower_high,
  output mefat_pkg::lane_t lane,
  output logic            prefix_high
);
  import mefat_pkg::*;

  // This lane is the first low line when every lower line is high
  assign lane.high      = echo_bit;
  assign lane.first_low = lower_high & ~echo_bit;
  assign prefix_high    = lower_high & echo_bit;

endmodule

### design/mefat_merge.sv
// Merges lane flags into the all-high status and the nearest sensor index.
// Depends on mefat_pkg.
module mefat_merge (
  input  mefat_pkg::lane_t                      lanes [mefat_pkg::NUM_SENSORS],
  output logic                                  all_high,
  output logic [mefat_pkg::NEAREST_W-1:0]       nearest
);
  import mefat_pkg::*;

  logic [NUM_SENSORS-1:0] high_vec;
  logic [NUM_SENSORS-2:0] first_vec;

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      high_vec[i] = lanes[i].high;
    end
    for (int i = 0; i < NUM_SENSORS - 1; i++) begin
      first_vec[i] = lanes[i].first_low;
    end
  end

  assign all_high = &high_vec;

  // first_vec is one-hot or zero, so an OR of indexes encodes it
  always_comb begin
    nearest = '0;
    for (int i = 0; i < NUM_SENSORS - 1; i++) begin
      if (first_vec[i]) begin
        nearest = nearest | NEAREST_W'(i);
      end
    end
    if (first_vec == '0) begin
      nearest = NEAREST_W'(NUM_SENSORS - 1);
    end
  end

endmodule

### design/mefat_ctrl.sv
// Sequencer: request edge, trigger pulse, elapsed counter and timeout check,
// plus the configuration registers. Depends on mefat_pkg.
module mefat_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mefat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mefat_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                               acc,
  input  logic                               req,
  input  logic                               all_high,
  input  logic [mefat_pkg::NEAREST_W-1:0]    nearest,
  output mefat_pkg::result_t                 res
);
  import mefat_pkg::*;

  logic [TIMEOUT_W-1:0] timeout_r;
  logic [TRIG_W-1:0]    trig_len_r;
  logic                 prev_req_r;
  phase_t               phase_r, phase_nxt;
  logic [TRIG_W-1:0]    pulse_r, pulse_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [TRIG_W-1:0]    pulse_dec;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= TIMEOUT_RST;
      trig_len_r <= TRIG_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TIMEOUT: timeout_r  <= cfg_wdata[TIMEOUT_W-1:0];
        REG_TRIGGER: trig_len_r <= cfg_wdata[TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturating count and pulse decrement
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign pulse_dec   = pulse_r - 1'b1;

  // Next state and result word
  always_comb begin
    phase_nxt   = phase_r;
    pulse_nxt   = pulse_r;
    elapsed_nxt = elapsed_r;
    res         = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (prev_req_r && !req) begin
          res.trigger_out = 1'b1;
          if (trig_len_r <= TRIG_W'(1)) begin
            phase_nxt   = PH_WAIT_HIGH;
            elapsed_nxt = '0;
          end else begin
            phase_nxt = PH_TRIGGER;
            pulse_nxt = trig_len_r - 1'b1;
          end
        end
      end
      PH_TRIGGER: begin
        res.trigger_out = 1'b1;
        pulse_nxt       = pulse_dec;
        if (pulse_dec == '0) begin
          phase_nxt   = PH_WAIT_HIGH;
          elapsed_nxt = '0;
        end
      end
      PH_WAIT_HIGH: begin
        elapsed_nxt = elapsed_inc;
        if (all_high) begin
          phase_nxt = PH_WAIT_DROP;
        end
      end
      PH_WAIT_DROP: begin
        elapsed_nxt = elapsed_inc;
        if (!all_high) begin
          res.result_valid   = 1'b1;
          res.nearest_sensor = nearest;
          res.elapsed_ticks  = elapsed_inc;
          phase_nxt          = PH_IDLE;
        end else if (elapsed_inc > {1'b0, timeout_r}) begin
          // timeout: report and re-arm without a new trigger
          res.result_valid   = 1'b1;
          res.timed_out      = 1'b1;
          res.nearest_sensor = nearest;
          res.elapsed_ticks  = elapsed_inc;
          phase_nxt          = PH_WAIT_HIGH;
          elapsed_nxt        = '0;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // State advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_req_r <= 1'b1;
      phase_r    <= PH_IDLE;
      pulse_r    <= '0;
      elapsed_r  <= '0;
    end else if (acc) begin
      prev_req_r <= req;
      phase_r    <= phase_nxt;
      pulse_r    <= pulse_nxt;
      elapsed_r  <= elapsed_nxt;
    end
  end

  // A result only ends an echo wait
  a_result_from_drop: assert property (@(posedge clk) disable iff (!rst_n)
    res.result_valid |-> phase_r == PH_WAIT_DROP)
    else $error("result outside echo wait");

  // Echo drop returns to idle
  a_drop_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && phase_r == PH_WAIT_DROP && !all_high |=> phase_r == PH_IDLE)
    else $error("echo drop did not return to idle");

  // Trigger drive only in idle or pulse phases
  a_trigger_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res.trigger_out |-> phase_r == PH_IDLE || phase_r == PH_TRIGGER)
    else $error("trigger driven while measuring");

  // Timeout restarts the count
  a_timeout_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.timed_out |=> phase_r == PH_WAIT_HIGH && elapsed_r == '0)
    else $error("timeout did not re-arm");

endmodule

### design/multi_echo_first_arrival_timer_unit.sv
// Top level of the multi-echo first-arrival timer: sensor lanes, merge,
// sequencer and output register. Depends on mefat_pkg and all mefat_ modules.
//
// Usage:
//   The input channel carries one word per sampled tick: the request line
//   level and the echo line levels. Every accepted word yields exactly one
//   result word: the trigger drive level, a result flag, and on a result the
//   nearest sensor, the elapsed tick count and a timeout flag.
//   A word accepted at an edge shows its result at the output register from
//   the next cycle on. Throughput is one word per cycle while the receiver
//   keeps taking results; the output register lets a new word in while the
//   previous result is taken in the same cycle.
//   If the receiver stalls, the held result blocks in_ready until it is
//   taken; no word is lost or repeated.
//   Reset (synchronous, active low) puts the sequencer in idle with the
//   request line taken as high, clears the counters, empties the output
//   register and loads the default timeout and trigger length.
//   Configuration writes take effect at the edge where cfg_wr_en is high and
//   are meant for when the block is idle.
module multi_echo_first_arrival_timer_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [mefat_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mefat_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_request_level,
  input  logic [mefat_pkg::ECHO_W-1:0]          in_echo_levels,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_trigger_out,
  output logic                                  out_result_valid,
  output logic [mefat_pkg::NEAREST_W-1:0]       out_nearest_sensor,
  output logic [mefat_pkg::ELAPSED_W-1:0]       out_elapsed_ticks,
  output logic                                  out_timed_out
);
  import mefat_pkg::*;

  logic                 in_acc;
  logic [NUM_SENSORS-1:0] echo_bits;
  logic [NUM_SENSORS:0]   prefix;
  lane_t                lanes [NUM_SENSORS];
  logic                 all_high;
  logic [NEAREST_W-1:0] nearest;
  result_t              res;
  result_t              out_word_r;
  logic                 out_valid_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // Sensor lanes; lines beyond the input width read low
  assign prefix[0] = 1'b1;
  for (genvar i = 0; i < NUM_SENSORS; i++) begin : g_lane
    if (i < ECHO_W) begin : g_in
      assign echo_bits[i] = in_echo_levels[i];
    end else begin : g_low
      assign echo_bits[i] = 1'b0;
    end
    mefat_lane u_lane (
      .echo_bit   (echo_bits[i]),
      .lower_high (prefix[i]),
      .lane       (lanes[i]),
      .prefix_high(prefix[i+1])
    );
  end

  mefat_merge u_merge (
    .lanes   (lanes),
    .all_high(all_high),
    .nearest (nearest)
  );

  mefat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .acc      (in_acc),
    .req      (in_request_level),
    .all_high (all_high),
    .nearest  (nearest),
    .res      (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_word_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_trigger_out    = out_word_r.trigger_out;
  assign out_result_valid   = out_word_r.result_valid;
  assign out_nearest_sensor = out_word_r.nearest_sensor;
  assign out_elapsed_ticks  = out_word_r.elapsed_ticks;
  assign out_timed_out      = out_word_r.timed_out;

endmodule

### test/tb_top.sv
// Testbench for multi_echo_first_arrival_timer_unit: directed and random tick words
// with random idling on both channels, each result word checked field by field.
// Depends on mefat_pkg and the design files of the block.
module tb_top;
  import mefat_pkg::*;

  localparam int LIMIT_CYCLES = 200000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_request_level = 1'b1;
  logic [ECHO_W-1:0]     in_echo_levels = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_trigger_out;
  logic                  out_result_valid;
  logic [NEAREST_W-1:0]  out_nearest_sensor;
  logic [ELAPSED_W-1:0]  out_elapsed_ticks;
  logic                  out_timed_out;

  // Predicted sequencer state and register copies
  phase_t                pred_phase;
  logic                  pred_prev_req;
  logic [TRIG_W-1:0]     pred_pulse_left;
  logic [ELAPSED_W-1:0]  pred_elapsed;
  logic [TIMEOUT_W-1:0]  timeout_reg;
  logic [TRIG_W-1:0]     trigger_len_reg;

  result_t               ranging_results_q[$];
  int                    mismatch_count = 0;
  int                    cycle_count = 0;
  int                    hold_cycles = 0;
  bit                    steady = 1'b0;

  multi_echo_first_arrival_timer_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_request_level   (in_request_level),
    .in_echo_levels     (in_echo_levels),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_trigger_out    (out_trigger_out),
    .out_result_valid   (out_result_valid),
    .out_nearest_sensor (out_nearest_sensor),
    .out_elapsed_ticks  (out_elapsed_ticks),
    .out_timed_out      (out_timed_out)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[multi_echo_first_arrival_timer_unit] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 31);
    end
  end

  // Echo line i, lines beyond the input width read low
  function automatic logic echo_line(input logic [ECHO_W-1:0] echo, input int i);
    return (i < ECHO_W) ? echo[i] : 1'b0;
  endfunction

  // Advance the predicted timer by one tick and return the word it produces
  task automatic ranging_step(input logic req, input logic [ECHO_W-1:0] echo,
                              output result_t res);
    logic                 all_high;
    logic [NEAREST_W-1:0] nearest;
    logic [TRIG_W-1:0]    len;
    all_high = 1'b1;
    for (int i = 0; i < NUM_SENSORS; i++)
      if (!echo_line(echo, i)) all_high = 1'b0;
    nearest = NEAREST_W'(NUM_SENSORS - 1);
    for (int i = NUM_SENSORS - 2; i >= 0; i--)
      if (!echo_line(echo, i)) nearest = NEAREST_W'(i);
    res = '0;
    case (pred_phase)
      PH_IDLE: begin
        if (pred_prev_req && !req) begin
          res.trigger_out = 1'b1;
          len = (trigger_len_reg == 0) ? TRIG_W'(1) : trigger_len_reg;
          if (len == 1) begin
            pred_phase = PH_WAIT_HIGH;
            pred_elapsed = '0;
          end else begin
            pred_phase = PH_TRIGGER;
            pred_pulse_left = len - 1'b1;
          end
        end
      end
      PH_TRIGGER: begin
        res.trigger_out = 1'b1;
        pred_pulse_left = pred_pulse_left - 1'b1;
        if (pred_pulse_left == 0) begin
          pred_phase = PH_WAIT_HIGH;
          pred_elapsed = '0;
        end
      end
      PH_WAIT_HIGH: begin
        if (pred_elapsed != ELAPSED_MAX) pred_elapsed = pred_elapsed + 1'b1;
        if (all_high) pred_phase = PH_WAIT_DROP;
      end
      PH_WAIT_DROP: begin
        if (pred_elapsed != ELAPSED_MAX) pred_elapsed = pred_elapsed + 1'b1;
        // a drop wins over a timeout on the same tick
        if (!all_high) begin
          res.result_valid = 1'b1;
          res.nearest_sensor = nearest;
          res.elapsed_ticks = pred_elapsed;
          pred_phase = PH_IDLE;
        end else if (pred_elapsed > ELAPSED_W'(timeout_reg)) begin
          res.result_valid = 1'b1;
          res.timed_out = 1'b1;
          res.nearest_sensor = nearest;
          res.elapsed_ticks = pred_elapsed;
          pred_phase = PH_WAIT_HIGH;
          pred_elapsed = '0;
        end
      end
      default: ;
    endcase
    pred_prev_req = req;
  endtask

  task automatic flag_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    mismatch_count++;
  endtask

  // Checker and predictor: result words are compared before the accepted
  // input word of this edge is predicted
  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (!rst_n) begin
      pred_phase = PH_IDLE;
      pred_prev_req = 1'b1;
      pred_pulse_left = '0;
      pred_elapsed = '0;
      timeout_reg = TIMEOUT_RST;
      trigger_len_reg = TRIG_RST;
      ranging_results_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_TIMEOUT) timeout_reg = cfg_wdata[TIMEOUT_W-1:0];
        else if (cfg_index == REG_TRIGGER) trigger_len_reg = cfg_wdata[TRIG_W-1:0];
      end
      if (out_valid && out_ready) begin
        got.trigger_out = out_trigger_out;
        got.result_valid = out_result_valid;
        got.nearest_sensor = out_nearest_sensor;
        got.elapsed_ticks = out_elapsed_ticks;
        got.timed_out = out_timed_out;
        if (ranging_results_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, got);
          mismatch_count++;
        end else begin
          want = ranging_results_q.pop_front();
          if (got.trigger_out !== want.trigger_out)
            flag_mismatch("trigger_out", want.trigger_out, got.trigger_out);
          if (got.result_valid !== want.result_valid)
            flag_mismatch("result_valid", want.result_valid, got.result_valid);
          if (got.nearest_sensor !== want.nearest_sensor)
            flag_mismatch("nearest_sensor", want.nearest_sensor, got.nearest_sensor);
          if (got.elapsed_ticks !== want.elapsed_ticks)
            flag_mismatch("elapsed_ticks", want.elapsed_ticks, got.elapsed_ticks);
          if (got.timed_out !== want.timed_out)
            flag_mismatch("timed_out", want.timed_out, got.timed_out);
        end
      end
      if (in_valid && in_ready) begin
        ranging_step(in_request_level, in_echo_levels, want);
        ranging_results_q.push_back(want);
      end
    end
  end

  // Offer one tick word after a random gap; returns at the falling edge
  // after acceptance with valid still high
  task automatic send_word(input logic req, input logic [ECHO_W-1:0] echo);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_request_level <= req;
    in_echo_levels <= echo;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Stop offering and wait for every predicted word to come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (ranging_results_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Finish any measurement in flight so the sequencer sits in idle
  task automatic return_to_idle();
    while (pred_phase != PH_IDLE) begin
      case (pred_phase)
        PH_WAIT_HIGH: send_word(1'b1, '1);
        PH_WAIT_DROP: send_word(1'b1, ~ECHO_W'(1));
        default:      send_word(1'b1, ECHO_W'($urandom));
      endcase
    end
  endtask

  // Random tick word shaped by the predicted phase; some words are pure noise
  task automatic pick_tick_word(output logic req, output logic [ECHO_W-1:0] echo);
    int k;
    req = 1'($urandom_range(0, 1));
    echo = ECHO_W'($urandom);
    k = $urandom_range(0, NUM_SENSORS - 1);
    if ($urandom_range(0, 9) == 0) return;
    case (pred_phase)
      PH_WAIT_HIGH: if ($urandom_range(0, 1) == 1) echo = '1;
      PH_WAIT_DROP: begin
        // mostly hold all lines high; a drop makes line k the first low one
        if ($urandom_range(0, 3) != 0) echo = '1;
        else echo = (echo | ((ECHO_W'(1) << k) - 1'b1)) & ~(ECHO_W'(1) << k);
      end
      default: ;
    endcase
  endtask

  task automatic send_random_words(input int count);
    logic              req;
    logic [ECHO_W-1:0] echo;
    repeat (count) begin
      pick_tick_word(req, echo);
      send_word(req, echo);
    end
  endtask

  // Default registers: ten-tick trigger with request edges inside the pulse,
  // then a drop with every line low
  task automatic test_default_trigger();
    send_word(1'b1, '0);
    send_word(1'b0, '1);
    while (pred_phase == PH_TRIGGER)
      send_word(1'($urandom_range(0, 1)), ECHO_W'($urandom));
    send_word(1'b1, '1);
    send_word(1'b1, '0);
  endtask

  // One-tick trigger, short timeout: timeout with re-arm, then a drop on the
  // tick that would also time out, with only the last line low
  task automatic test_timeout_rearm();
    return_to_idle();
    write_reg(REG_TRIGGER, 1);
    write_reg(REG_TIMEOUT, 2);
    send_word(1'b0, '1);
    send_word(1'b1, ECHO_W'(8'h7F));
    send_word(1'b1, '1);
    send_word(1'b1, '1);
    send_word(1'b1, '1);
    send_word(1'b1, '1);
    send_word(1'b1, ECHO_W'(8'h7F));
  endtask

  // Zero trigger length acts as one tick; largest timeout; a request edge
  // while measuring is ignored
  task automatic test_zero_trigger();
    return_to_idle();
    write_reg(REG_TRIGGER, 0);
    write_reg(REG_TIMEOUT, 1048575);
    send_word(1'b0, ECHO_W'(8'h80));
    send_word(1'b1, '1);
    send_word(1'b0, '1);
    send_word(1'b1, ECHO_W'(8'hBF));
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    return_to_idle();
    write_reg(REG_TRIGGER, 3);
    write_reg(REG_TIMEOUT, 5);
    steady = 1'b1;
    hold_cycles = 60;
    send_random_words(30);
    steady = 1'b0;
  endtask

  // Phases of random measurements, registers rewritten between phases
  task automatic test_random_ranging();
    int unsigned tmo;
    int unsigned trg;
    int          count;
    for (int p = 0; p < 8; p++) begin
      count = 20;
      case (p)
        0: begin tmo = 1;                       trg = $urandom_range(1, 4); end
        1: begin tmo = $urandom_range(2, 30);   trg = 2;                    end
        2: begin tmo = 0;                       trg = 0;                    end
        3: begin tmo = 1048575;                 trg = 255; count = 20;      end
        4: begin tmo = $urandom_range(0, 15);   trg = $urandom_range(1, 6); end
        default: begin tmo = $urandom_range(0, 60); trg = $urandom_range(1, 5); end
      endcase
      return_to_idle();
      write_reg(REG_TIMEOUT, tmo);
      write_reg(REG_TRIGGER, trg);
      // one phase runs with no idling on either side
      steady = (p == 4);
      send_random_words(count);
      steady = 1'b0;
    end
    return_to_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_trigger();
    test_timeout_rearm();
    test_zero_trigger();
    test_backpressure();
    test_random_ranging();
    drain_results();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0)
      $display("[multi_echo_first_arrival_timer_unit] OK");
    else
      $display("[multi_echo_first_arrival_timer_unit] ERROR");
    $finish;
  end

endmodule

### multi_echo_first_arrival_timer_unit.f
design/mefat_pkg.sv
design/mefat_lane.sv
design/mefat_merge.sv
design/mefat_ctrl.sv
design/multi_echo_first_arrival_timer_unit.sv
test/tb_top.sv
